// File: rtl/core/urs_pkg.sv
// Shared types, codes and constants of the ultrasonic ranger sequencer.
`timescale 1ns / 1ps

package urs_pkg;

    // Field widths of the channels.
    localparam int unsigned OP_W       = 2;
    localparam int unsigned CH_FIELD_W = 2;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DIST_W     = 16;
    localparam int unsigned SCALE_W    = 16;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Defaults for the top-level parameters.
    localparam int unsigned CHANNELS_DEF   = 4;
    localparam int unsigned FILTER_LEN_DEF = 8;

    // Depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Configuration reset values.
    localparam logic [TIME_W-1:0]  REARM_RST        = 32'd60000;
    localparam logic [TIME_W-1:0]  TRIG_WIDTH_RST   = 32'd10;
    localparam logic [TIME_W-1:0]  ECHO_TIMEOUT_RST = 32'd30000;
    localparam logic [SCALE_W-1:0] MM_SCALE_RST     = 16'd11272;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_RISE = 2'd1,
        OP_FALL = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REARM        = 2'd0,
        CFG_TRIG_WIDTH   = 2'd1,
        CFG_ECHO_TIMEOUT = 2'd2,
        CFG_MM_SCALE     = 2'd3
    } t_cfg_idx;

    // Request class decided by the front.
    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_RISE,
        KIND_FALL,
        KIND_NONE,
        KIND_SKIP
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_ECHO
    } t_phase;

    typedef struct packed {
        t_kind                 kind;
        logic [CH_FIELD_W-1:0] channel;
        logic [TIME_W-1:0]     now_us;
    } t_req;

    typedef struct packed {
        logic [TIME_W-1:0]  rearm_us;
        logic [TIME_W-1:0]  trig_width_us;
        logic [TIME_W-1:0]  echo_timeout_us;
        logic [SCALE_W-1:0] mm_per_us_q16;
    } t_cfg;

endpackage

// File: rtl/core/urs_in_if.sv
// Event request channel into the ranger.
`timescale 1ns / 1ps

interface urs_in_if;
    logic                            valid;
    logic                            ready;
    logic [urs_pkg::OP_W-1:0]        opcode;
    logic [urs_pkg::CH_FIELD_W-1:0]  channel;
    logic [urs_pkg::TIME_W-1:0]      now_us;

    modport source (output valid, opcode, channel, now_us, input ready);
    modport sink   (input valid, opcode, channel, now_us, output ready);
endinterface

// File: rtl/core/urs_out_if.sv
// Result channel out of the ranger.
`timescale 1ns / 1ps

interface urs_out_if;
    logic                            valid;
    logic                            ready;
    logic [urs_pkg::CH_FIELD_W-1:0]  out_channel;
    logic                            trigger_level;
    logic                            trigger_started;
    logic                            measured;
    logic [urs_pkg::TIME_W-1:0]      echo_us;
    logic [urs_pkg::DIST_W-1:0]      distance_mm;
    logic [urs_pkg::DIST_W-1:0]      filtered_mm;
    logic [urs_pkg::COUNT_W-1:0]     frame_count;
    logic                            watchdog_feed;

    modport source (output valid, out_channel, trigger_level, trigger_started, measured,
                    echo_us, distance_mm, filtered_mm, frame_count, watchdog_feed,
                    input ready);
    modport sink   (input valid, out_channel, trigger_level, trigger_started, measured,
                    echo_us, distance_mm, filtered_mm, frame_count, watchdog_feed,
                    output ready);
endinterface

// File: rtl/core/urs_cfg_if.sv
// Configuration write channel of the ranger.
`timescale 1ns / 1ps

interface urs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [urs_pkg::CFG_IDX_W-1:0]   index;
    logic [urs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/urs_front.sv
// Front stage: accept event requests and classify them.
`timescale 1ns / 1ps

module urs_front #(
    parameter int unsigned CHANNELS = urs_pkg::CHANNELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    urs_in_if.sink        i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output urs_pkg::t_req o_req
);

    logic          r_valid;
    urs_pkg::t_req r_req;
    urs_pkg::t_req n_req;

    assign i_req.ready = !r_valid || i_ready;

    always_comb begin
        n_req.channel = i_req.channel;
        n_req.now_us  = i_req.now_us;
        if (32'(i_req.channel) >= CHANNELS) begin
            n_req.kind = urs_pkg::KIND_SKIP;
        end else begin
            case (urs_pkg::t_opcode'(i_req.opcode))
                urs_pkg::OP_TICK: n_req.kind = urs_pkg::KIND_TICK;
                urs_pkg::OP_RISE: n_req.kind = urs_pkg::KIND_RISE;
                urs_pkg::OP_FALL: n_req.kind = urs_pkg::KIND_FALL;
                default:          n_req.kind = urs_pkg::KIND_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// File: rtl/core/urs_queue.sv
// Short request queue between front and back.
`timescale 1ns / 1ps

module urs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  urs_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output urs_pkg::t_req o_req
);

    localparam int unsigned DEPTH = urs_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    urs_pkg::t_req    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_req   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

// File: rtl/core/urs_back.sv
// Back pipeline: channel sequencing, distance scaling, averaging filter.
`timescale 1ns / 1ps

module urs_back #(
    parameter int unsigned CHANNELS   = urs_pkg::CHANNELS_DEF,
    parameter int unsigned FILTER_LEN = urs_pkg::FILTER_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  urs_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  urs_pkg::t_req i_req,
    urs_out_if.source     o_rsp
);

    localparam int unsigned TW       = urs_pkg::TIME_W;
    localparam int unsigned DW       = urs_pkg::DIST_W;
    localparam int unsigned CW       = urs_pkg::COUNT_W;
    localparam int unsigned PROD_W   = urs_pkg::TIME_W + urs_pkg::SCALE_W;
    localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned SLOT_W   = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;
    localparam int unsigned LOG_LEN  = $clog2(FILTER_LEN);
    localparam int unsigned SUM_W    = DW + LOG_LEN;
    // Division by FILTER_LEN as a reciprocal multiply, exact over the sum range.
    localparam int unsigned RCP_SH   = SUM_W + LOG_LEN;
    localparam int unsigned RCP_W    = SUM_W + 2;
    localparam logic [63:0] RCP_FULL = ((64'd1 << RCP_SH) + 64'(FILTER_LEN) - 64'd1)
                                       / 64'(FILTER_LEN);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);
    localparam int unsigned FPROD_W  = SUM_W + RCP_W;

    typedef struct packed {
        logic                          skip;
        logic [urs_pkg::CH_FIELD_W-1:0] channel;
        logic [CH_W-1:0]               idx;
        logic [SLOT_W-1:0]             slot;
        logic                          wrapped;
        logic                          pin;
        logic                          started;
        logic                          measured;
        logic                          feed;
        logic [CW-1:0]                 frames;
        logic [TW-1:0]                 echo;
    } t_s1;

    typedef struct packed {
        t_s1                 s1;
        logic [PROD_W-1:0]   prod;
    } t_s2;

    typedef struct packed {
        t_s1                 s1;
        logic [DW-1:0]       dist_mm;
        logic [SUM_W-1:0]    sum;
    } t_s3;

    // Per-channel state.
    urs_pkg::t_phase   r_phase      [CHANNELS];
    logic [TW-1:0]     r_trig_start [CHANNELS];
    logic [TW-1:0]     r_trig_end   [CHANNELS];
    logic [TW-1:0]     r_echo_start [CHANNELS];
    logic [TW-1:0]     r_echo_end   [CHANNELS];
    logic              r_pin        [CHANNELS];
    logic [CW-1:0]     r_frames     [CHANNELS];
    logic [SLOT_W-1:0] r_slot       [CHANNELS];
    logic              r_wrapped    [CHANNELS];
    logic [SUM_W-1:0]  r_sum        [CHANNELS];

    // Distance history.
    logic [DW-1:0]     r_hist [CHANNELS][FILTER_LEN];
    logic [DW-1:0]     r_rd_data;
    logic              r_byp_hit;
    logic [DW-1:0]     r_byp_data;

    // Pipeline.
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_s1  r_s1;
    t_s2  r_s2;
    t_s3  r_s3;
    t_s1  n_s1;

    logic                   en;
    logic                   upd;
    logic [CH_W-1:0]        idx;
    urs_pkg::t_phase        cur_phase;
    urs_pkg::t_phase        n_phase;
    logic [TW-1:0]          ref_time;
    logic [TW-1:0]          limit;
    logic [TW-1:0]          elapsed;
    logic                   due;
    logic                   set_trig_start;
    logic                   set_trig_end;
    logic                   set_echo_start;
    logic                   set_echo_end;
    logic [SLOT_W-1:0]      n_slot;
    logic                   n_wrapped;
    logic                   last_slot;

    logic [DW-1:0]          s3_dist;
    logic [DW-1:0]          s3_old;
    logic [SUM_W-1:0]       s3_sum;
    logic                   hist_we;
    logic [FPROD_W-1:0]     fprod;

    // Output register.
    t_s1                    r_out;
    logic [DW-1:0]          r_out_dist;
    logic [DW-1:0]          r_out_filt;

    assign en      = !r_out_valid || o_rsp.ready;
    assign o_ready = en;
    assign upd     = en && i_valid && (i_req.kind != urs_pkg::KIND_SKIP);

    // ---------------- stage 1: channel sequencing ----------------
    assign idx       = CH_W'(i_req.channel);
    assign cur_phase = r_phase[idx];
    assign last_slot = (r_slot[idx] == SLOT_W'(FILTER_LEN - 1));

    always_comb begin
        case (cur_phase)
            urs_pkg::PH_IDLE: begin
                ref_time = r_echo_end[idx];
                limit    = i_cfg.rearm_us;
            end
            urs_pkg::PH_TRIG: begin
                ref_time = r_trig_start[idx];
                limit    = i_cfg.trig_width_us;
            end
            default: begin
                ref_time = r_trig_end[idx];
                limit    = i_cfg.echo_timeout_us;
            end
        endcase
        elapsed = i_req.now_us - ref_time;
        due     = elapsed > limit;
    end

    always_comb begin
        n_phase        = cur_phase;
        set_trig_start = 1'b0;
        set_trig_end   = 1'b0;
        set_echo_start = 1'b0;
        set_echo_end   = 1'b0;
        n_slot         = r_slot[idx];
        n_wrapped      = r_wrapped[idx];

        n_s1.skip      = (i_req.kind == urs_pkg::KIND_SKIP);
        n_s1.channel   = i_req.channel;
        n_s1.idx       = idx;
        n_s1.slot      = r_slot[idx];
        n_s1.wrapped   = r_wrapped[idx];
        n_s1.pin       = r_pin[idx];
        n_s1.started   = 1'b0;
        n_s1.measured  = 1'b0;
        n_s1.feed      = 1'b0;
        n_s1.frames    = r_frames[idx];
        n_s1.echo      = '0;

        case (i_req.kind)
            urs_pkg::KIND_TICK: begin
                if (due) begin
                    case (cur_phase)
                        urs_pkg::PH_IDLE, urs_pkg::PH_WAIT: begin
                            n_phase        = urs_pkg::PH_TRIG;
                            n_s1.pin       = 1'b1;
                            n_s1.started   = 1'b1;
                            set_trig_start = 1'b1;
                        end
                        urs_pkg::PH_TRIG: begin
                            n_phase      = urs_pkg::PH_WAIT;
                            n_s1.pin     = 1'b0;
                            set_trig_end = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            urs_pkg::KIND_RISE: begin
                n_phase        = urs_pkg::PH_ECHO;
                n_s1.feed      = 1'b1;
                set_echo_start = 1'b1;
            end
            urs_pkg::KIND_FALL: begin
                n_phase       = urs_pkg::PH_IDLE;
                n_s1.feed     = 1'b1;
                n_s1.measured = 1'b1;
                n_s1.frames   = r_frames[idx] + 1'b1;
                n_s1.echo     = i_req.now_us - r_echo_start[idx];
                set_echo_end  = 1'b1;
                n_slot        = last_slot ? '0 : r_slot[idx] + 1'b1;
                n_wrapped     = r_wrapped[idx] || last_slot;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_phase[c]      <= urs_pkg::PH_IDLE;
                r_trig_start[c] <= '0;
                r_trig_end[c]   <= '0;
                r_echo_start[c] <= '0;
                r_echo_end[c]   <= '0;
                r_pin[c]        <= 1'b0;
                r_frames[c]     <= '0;
                r_slot[c]       <= '0;
                r_wrapped[c]    <= 1'b0;
            end
        end else if (upd) begin
            r_phase[idx]   <= n_phase;
            r_pin[idx]     <= n_s1.pin;
            r_frames[idx]  <= n_s1.frames;
            r_slot[idx]    <= n_slot;
            r_wrapped[idx] <= n_wrapped;
            if (set_trig_start) begin
                r_trig_start[idx] <= i_req.now_us;
            end
            if (set_trig_end) begin
                r_trig_end[idx] <= i_req.now_us;
            end
            if (set_echo_start) begin
                r_echo_start[idx] <= i_req.now_us;
            end
            if (set_echo_end) begin
                r_echo_end[idx] <= i_req.now_us;
            end
        end
    end

    // ---------------- stage 2: scale multiply, history read ----------------
    // Stage 3 logic, needed here for the same-address bypass.
    assign s3_dist = (|r_s2.prod[PROD_W-1:TW]) ? {DW{1'b1}} : r_s2.prod[TW-1:DW];
    assign hist_we = en && r_s2_valid && r_s2.s1.measured;
    assign s3_old  = r_byp_hit ? r_byp_data : (r_s2.s1.wrapped ? r_rd_data : '0);
    assign s3_sum  = r_sum[r_s2.s1.idx] - SUM_W'(s3_old) + SUM_W'(s3_dist);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_data  <= r_hist[r_s1.idx][r_s1.slot];
            r_byp_hit  <= hist_we && (r_s2.s1.idx == r_s1.idx) && (r_s2.s1.slot == r_s1.slot);
            r_byp_data <= s3_dist;
        end
        if (hist_we) begin
            r_hist[r_s2.s1.idx][r_s2.s1.slot] <= s3_dist;
        end
    end

    // ---------------- stage 3: running sum ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else if (hist_we) begin
            r_sum[r_s2.s1.idx] <= s3_sum;
        end
    end

    // ---------------- stage 4: average by reciprocal ----------------
    assign fprod = FPROD_W'(r_s3.sum) * FPROD_W'(RCP);

    // Pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1         <= n_s1;
            r_s2.s1      <= r_s1;
            r_s2.prod    <= PROD_W'(r_s1.echo) * PROD_W'(i_cfg.mm_per_us_q16);
            r_s3.s1      <= r_s2.s1;
            r_s3.dist_mm <= s3_dist;
            r_s3.sum     <= s3_sum;
            r_out        <= r_s3.s1;
            r_out_dist   <= r_s3.dist_mm;
            r_out_filt   <= fprod[RCP_SH +: DW];
        end
    end

    // Out-of-range channels report only their channel; non-measurements report no distances.
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.out_channel     = r_out.channel;
    assign o_rsp.trigger_level   = !r_out.skip && r_out.pin;
    assign o_rsp.trigger_started = !r_out.skip && r_out.started;
    assign o_rsp.measured        = !r_out.skip && r_out.measured;
    assign o_rsp.echo_us         = (!r_out.skip && r_out.measured) ? r_out.echo : '0;
    assign o_rsp.distance_mm     = (!r_out.skip && r_out.measured) ? r_out_dist : '0;
    assign o_rsp.filtered_mm     = (!r_out.skip && r_out.measured) ? r_out_filt : '0;
    assign o_rsp.frame_count     = r_out.skip ? '0 : r_out.frames;
    assign o_rsp.watchdog_feed   = !r_out.skip && r_out.feed;

endmodule

// File: rtl/core/ultrasonic_ranger_sequencer.sv
// Top level of the multi-channel ultrasonic ranger sequencer.
`timescale 1ns / 1ps

// Multi-channel ultrasonic ranger. Each request on i_req names a channel, a microsecond
// timestamp and an event (tick, echo rising edge, echo falling edge), and every request
// gives exactly one result on o_rsp, in request order. Ticks walk a channel through
// idle, trigger and wait: the trigger rises once the re-arm interval after the last echo
// has passed, drops after the pulse width, and rises again when the echo timeout runs
// out. A rising edge marks the echo start; a falling edge reports the echo time, the
// distance in millimetres (echo time times mm_per_us_q16, Q0.16, saturated to 16 bits),
// a moving average over the last FILTER_LEN distances and the channel's frame count.
// Throughput is one request per clock cycle while o_rsp is ready. A request passes
// one front register that classifies it, a four-entry queue, then four back stages
// (channel sequencing, scale multiply with history read, running-sum update,
// reciprocal multiply for the average) ending in the output register. When o_rsp
// stalls, the back pipeline holds while the queue and front register keep taking
// requests until they fill. Configuration writes on i_cfg are always taken (ready is
// tied high) and should be made only while idle.
// History memory entries not yet written read as zero, tracked by a per-channel wrap flag,
// so no clearing pass follows reset.

module ultrasonic_ranger_sequencer #(
    parameter int unsigned CHANNELS   = urs_pkg::CHANNELS_DEF,
    parameter int unsigned FILTER_LEN = urs_pkg::FILTER_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    urs_in_if.sink    i_req,
    urs_out_if.source o_rsp,
    urs_cfg_if.sink   i_cfg
);

    // Configuration registers, shared by every channel.
    urs_pkg::t_cfg r_cfg;

    // Front to queue.
    logic          front_valid;
    logic          front_ready;
    urs_pkg::t_req front_req;

    // Queue to back.
    logic          queue_valid;
    logic          queue_ready;
    urs_pkg::t_req queue_req;

    // Take every configuration write at once.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rearm_us        <= urs_pkg::REARM_RST;
            r_cfg.trig_width_us   <= urs_pkg::TRIG_WIDTH_RST;
            r_cfg.echo_timeout_us <= urs_pkg::ECHO_TIMEOUT_RST;
            r_cfg.mm_per_us_q16   <= urs_pkg::MM_SCALE_RST;
        end else if (i_cfg.valid) begin
            case (urs_pkg::t_cfg_idx'(i_cfg.index))
                urs_pkg::CFG_REARM:        r_cfg.rearm_us        <= i_cfg.data;
                urs_pkg::CFG_TRIG_WIDTH:   r_cfg.trig_width_us   <= i_cfg.data;
                urs_pkg::CFG_ECHO_TIMEOUT: r_cfg.echo_timeout_us <= i_cfg.data;
                urs_pkg::CFG_MM_SCALE:     r_cfg.mm_per_us_q16   <=
                                               i_cfg.data[urs_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify incoming requests; out-of-range channels are marked to pass untouched.
    urs_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_req   (front_req)
    );

    // Hold classified requests while the back pipeline stalls.
    urs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_req   (front_req),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_req   (queue_req)
    );

    // Sequence the channels and compute measurements.
    urs_back #(
        .CHANNELS   (CHANNELS),
        .FILTER_LEN (FILTER_LEN)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (queue_valid),
        .o_ready (queue_ready),
        .i_req   (queue_req),
        .o_rsp   (o_rsp)
    );

endmodule
